// ----- sv/dpq_pkg.sv -----
// Package for the double-ended priority queue.
// Holds operation codes, capacity default and width helpers; no dependencies.
package dpq_pkg;
  localparam int unsigned DefCapacity = 1024;
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelMin = 2'd1;
  localparam logic [1:0] OpDelMax = 2'd2;
  localparam int unsigned KeyW = 32;
  localparam int unsigned CountW = 11;
endpackage

// ----- sv/dpq_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module dpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/double_ended_priority_queue.sv -----
// Top level: symmetric min-max heap priority queue with its sequencer.
// Depends on dpq_pkg and dpq_ram.
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_ready_o, operation_i, value_i | sink
//  out     | out_valid_o, out_ready_i, is_empty_o, entry_count_o,
//          | min_value_o, max_value_o, rejected_o       | source
//
// Each item sifts through the tree level by level, paced by the single RAM port;
// a sift may stop early, before it reaches the root or a leaf.
// The extremes are read back from nodes 2 and 3 at the end of every item.
// Reset clears the count and control; the RAM needs no clearing.
// A new item is taken once the previous result has moved into the output register;
// a stalled output holds the next result in its final state.
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = dpq_pkg::DefCapacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      operation_i,
  input  logic signed [dpq_pkg::KeyW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_empty_o,
  output logic [dpq_pkg::CountW-1:0]      entry_count_o,
  output logic signed [dpq_pkg::KeyW-1:0] min_value_o,
  output logic signed [dpq_pkg::KeyW-1:0] max_value_o,
  output logic                            rejected_o
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NW = $clog2(CAPACITY + 2) + 2;
  localparam int unsigned CW = dpq_pkg::CountW;
  localparam int unsigned KW = dpq_pkg::KeyW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDA   = 5'd1;
  localparam logic [4:0] S_WTA   = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_WTB   = 5'd4;
  localparam logic [4:0] S_CMP   = 5'd5;
  localparam logic [4:0] S_WRA   = 5'd6;
  localparam logic [4:0] S_WRB   = 5'd7;
  localparam logic [4:0] S_RDC   = 5'd8;
  localparam logic [4:0] S_WTC   = 5'd9;
  localparam logic [4:0] S_RDD   = 5'd10;
  localparam logic [4:0] S_WTD   = 5'd11;
  localparam logic [4:0] S_CCMP  = 5'd12;
  localparam logic [4:0] S_TOP0  = 5'd13;
  localparam logic [4:0] S_TOP0W = 5'd14;
  localparam logic [4:0] S_TOP1  = 5'd15;
  localparam logic [4:0] S_TOP1W = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;
  localparam logic [4:0] S_LAST  = 5'd18;
  localparam logic [4:0] S_LASTW = 5'd19;

  // Phase: insert sibling, insert grandparent, delete sibling, delete children.
  localparam logic [1:0] P_ISIB = 2'd0;
  localparam logic [1:0] P_IGRD = 2'd1;
  localparam logic [1:0] P_DSIB = 2'd2;
  localparam logic [1:0] P_DCHD = 2'd3;

  logic [4:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] cur_q, cur_d, na_q, na_d, nb_q, nb_d, nc_q, nc_d;
  logic [KW-1:0] ka_q, ka_d, kb_q, kb_d, kc_q, kc_d;
  logic [KW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic rej_q, rej_d, ovalid_q, ovalid_d;
  logic gsecond_q, gsecond_d;
  logic oempty_q, oempty_d, orej_q, orej_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [KW-1:0] omin_q, omin_d, omax_q, omax_d;

  logic we;
  logic [NW-1:0] anode;
  logic [KW-1:0] wdata, rdata;
  logic [AW-1:0] addr;
  logic [NW-1:0] bound;
  logic [NW-1:0] tmp;

  assign addr = tmp[AW-1:0];
  assign bound = NW'(cnt_q) + NW'(2);

  dpq_ram #(.Width(KW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic gt(input logic [KW-1:0] a, input logic [KW-1:0] b);
    gt = $signed(a) > $signed(b);
  endfunction

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    st_d = st_q; ph_d = ph_q; cnt_d = cnt_q; cur_d = cur_q;
    na_d = na_q; nb_d = nb_q; nc_d = nc_q;
    ka_d = ka_q; kb_d = kb_q; kc_d = kc_q;
    lo_d = lo_q; hi_d = hi_q; rej_d = rej_q; ovalid_d = ovalid_q;
    gsecond_d = gsecond_q;
    oempty_d = oempty_q; ocnt_d = ocnt_q; omin_d = omin_q; omax_d = omax_q;
    orej_d = orej_q;
    we = 1'b0; anode = NW'(2); wdata = ka_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          rej_d = 1'b0;
          case (operation_i)
            dpq_pkg::OpInsert: begin
              if (32'(cnt_q) >= CAPACITY) begin
                rej_d = 1'b1; st_d = S_TOP0;
              end else begin
                we = 1'b1; anode = bound; wdata = value_i;
                cur_d = bound; ka_d = value_i;
                cnt_d = cnt_q + CW'(1);
                ph_d = P_ISIB; st_d = S_RDA;
              end
            end
            dpq_pkg::OpDelMin, dpq_pkg::OpDelMax: begin
              if (cnt_q == '0) begin
                rej_d = 1'b1; st_d = S_TOP0;
              end else if (operation_i == dpq_pkg::OpDelMax && cnt_q == CW'(1)) begin
                cnt_d = '0; st_d = S_TOP0;
              end else begin
                cur_d = (operation_i == dpq_pkg::OpDelMin) ? NW'(2) : NW'(3);
                anode = NW'(cnt_q) + NW'(1);
                st_d = S_LAST;
              end
            end
            default: begin
              rej_d = 1'b1; st_d = S_TOP0;
            end
          endcase
        end
      end
      S_LAST: begin
        anode = NW'(cnt_q) + NW'(1); st_d = S_LASTW;
      end
      S_LASTW: begin
        we = 1'b1; anode = cur_q; wdata = rdata; ka_d = rdata;
        cnt_d = cnt_q - CW'(1);
        ph_d = P_DSIB; st_d = S_RDA;
      end
      // Read the node under work (its key is kept in ka) and set up partner.
      S_RDA: begin
        anode = cur_q;
        case (ph_q)
          P_ISIB, P_DSIB: begin
            if (!cur_q[0]) begin
              nb_d = cur_q + NW'(1);
              if (cur_q + NW'(1) >= bound) begin
                st_d = (ph_q == P_ISIB) ? S_RDA : S_RDA;
                if (ph_q == P_ISIB) ph_d = P_IGRD; else ph_d = P_DCHD;
              end else begin
                st_d = S_RDB;
              end
            end else begin
              nb_d = cur_q - NW'(1); st_d = S_RDB;
            end
          end
          P_IGRD: begin
            if (cur_q <= NW'(3)) begin
              st_d = S_TOP0;
            end else begin
              gsecond_d = 1'b0;
              nb_d = (cur_q >> 2) << 1;
              st_d = S_RDB;
            end
          end
          default: begin
            if (!cur_q[0]) begin
              nb_d = cur_q << 1; nc_d = (cur_q << 1) + NW'(2);
            end else begin
              nb_d = (cur_q << 1) - NW'(1); nc_d = (cur_q << 1) + NW'(1);
            end
            if (!cur_q[0] ? ((cur_q << 1) >= bound) : (((cur_q << 1) - NW'(1)) >= bound))
              begin
              st_d = S_TOP0;
            end else begin
              st_d = S_RDC;
            end
          end
        endcase
      end
      S_RDB: begin
        anode = nb_q; st_d = S_WTB;
      end
      S_WTB: begin
        anode = nb_q; kb_d = rdata; st_d = S_CMP;
      end
      S_CMP: begin
        case (ph_q)
          P_ISIB, P_DSIB: begin
            if (!cur_q[0] ? gt(ka_q, kb_q) : gt(kb_q, ka_q)) begin
              st_d = S_WRA;
            end else begin
              ph_d = (ph_q == P_ISIB) ? P_IGRD : P_DCHD;
              st_d = S_RDA;
            end
          end
          default: begin
            if (!gsecond_q) begin
              if (gt(kb_q, ka_q)) begin
                st_d = S_WRA;
              end else begin
                gsecond_d = 1'b1; nb_d = nb_q + NW'(1); st_d = S_RDB;
              end
            end else if (gt(ka_q, kb_q)) begin
              st_d = S_WRA;
            end else begin
              st_d = S_TOP0;
            end
          end
        endcase
      end
      // Swap: node cur gets kb, node nb gets ka. Work continues at nb, except after a
      // sibling swap on the way down, which stays at cur with the sibling's key.
      S_WRA: begin
        we = 1'b1; anode = cur_q; wdata = kb_q; st_d = S_WRB;
      end
      S_WRB: begin
        we = 1'b1; anode = nb_q; wdata = ka_q; cur_d = nb_q;
        if (ph_q == P_DSIB) begin
          cur_d = cur_q; ka_d = kb_q;
        end
        case (ph_q)
          P_ISIB: ph_d = P_IGRD;
          P_IGRD: ph_d = P_ISIB;
          P_DSIB: ph_d = P_DCHD;
          default: ph_d = P_DSIB;
        endcase
        if (ph_q == P_DCHD && nb_q >= bound) st_d = S_TOP0;
        else st_d = S_RDA;
      end
      S_RDC: begin
        anode = nc_q; na_d = nb_q; st_d = S_WTC;
      end
      S_WTC: begin
        anode = na_q; kc_d = rdata; st_d = S_RDD;
      end
      S_RDD: begin
        anode = na_q; st_d = S_WTD;
      end
      S_WTD: begin
        kb_d = rdata; st_d = S_CCMP;
      end
      S_CCMP: begin
        // kb: child a, kc: child b (only valid when nc < bound).
        if (nc_q < bound && (!cur_q[0] ? gt(kb_q, kc_q) : gt(kc_q, kb_q))) begin
          kb_d = kc_q; nb_d = nc_q;
          if (!cur_q[0] ? gt(ka_q, kc_q) : gt(kc_q, ka_q)) st_d = S_WRA;
          else st_d = S_TOP0;
        end else begin
          nb_d = na_q;
          if (!cur_q[0] ? gt(ka_q, kb_q) : gt(kb_q, ka_q)) st_d = S_WRA;
          else st_d = S_TOP0;
        end
      end
      S_TOP0: begin
        anode = NW'(2); st_d = S_TOP0W;
      end
      S_TOP0W: begin
        anode = NW'(3); lo_d = rdata; st_d = S_TOP1;
      end
      S_TOP1: begin
        anode = NW'(3); st_d = S_TOP1W;
      end
      S_TOP1W: begin
        hi_d = rdata; st_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1; st_d = S_IDLE;
          oempty_d = (cnt_q == '0);
          ocnt_d = cnt_q;
          omin_d = (cnt_q == '0) ? '0 : lo_q;
          omax_d = (cnt_q == '0) ? '0 : ((cnt_q == CW'(1)) ? lo_q : hi_q);
          orej_d = rej_q;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign tmp = anode - NW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ph_q <= P_ISIB; cnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; na_q <= na_d; nb_q <= nb_d; nc_q <= nc_d;
    ka_q <= ka_d; kb_q <= kb_d; kc_q <= kc_d;
    lo_q <= lo_d; hi_q <= hi_d; rej_q <= rej_d; gsecond_q <= gsecond_d;
    oempty_q <= oempty_d; ocnt_q <= ocnt_d; omin_q <= omin_d; omax_q <= omax_d;
    orej_q <= orej_d;
  end

  assign is_empty_o = oempty_q;
  assign entry_count_o = ocnt_q;
  assign min_value_o = omin_q;
  assign max_value_o = omax_q;
  assign rejected_o = orej_q;
endmodule
